/* design/lge_pkg.sv */
// Package for the life generation engine: grid sizes, command codes,
// register indexes and the edge-mask struct. No dependencies.
`timescale 1ns / 1ps

package lge_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 256;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int GRID_CELLS = MAX_ROWS * MAX_COLS;
  localparam int NR_W       = 7;
  localparam int NC_W       = 9;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_W       = 24;
  localparam int OUT_W      = 8;
  // center of the 3x3 window trails the read pointer by one line plus pipeline
  localparam int LAG        = MAX_COLS + 3;
  localparam int STEP_END   = GRID_CELLS + LAG - 1;
  localparam int CNT_W      = $clog2(STEP_END + 1);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  typedef struct packed {
    logic top_ok;
    logic bottom_ok;
    logic left_ok;
    logic right_ok;
  } lge_edge_t;

endpackage

/* design/lge_cell.sv */
// One slot of the two-line buffer: holds the current-line and previous-line
// bit of one column and hands both on to the next slot. Uses lge_pkg.
`timescale 1ns / 1ps

module lge_cell (
  input  logic clk,
  input  logic shift,
  input  logic a_in,
  input  logic b_in,
  output logic a_out,
  output logic b_out
);
  import lge_pkg::*;

  logic a;
  logic b;

  always_ff @(posedge clk) begin
    if (shift) begin
      a <= a_in;
      b <= b_in;
    end
  end

  assign a_out = a;
  assign b_out = b;

endmodule

/* design/lge_rule.sv */
// 3x3 window over the streamed grid, edge masking, neighbor count and the
// B3/S23 rule. Uses lge_pkg for the edge-mask struct.
`timescale 1ns / 1ps

module lge_rule (
  input  logic               clk,
  input  logic               shift,
  input  logic [2:0]         col_in,   // [0] row r-2, [1] row r-1, [2] row r
  input  lge_pkg::lge_edge_t edge_ok,
  output logic               next_bit
);
  import lge_pkg::*;

  logic [2:0] w0;
  logic [2:0] w1;
  logic [2:0] w2;
  logic [2:0] left_c;
  logic [2:0] right_c;
  logic       up_c;
  logic       dn_c;
  logic [3:0] n;

  always_ff @(posedge clk) begin
    if (shift) begin
      w0 <= w1;
      w1 <= w2;
      w2 <= col_in;
    end
  end

  always_comb begin
    left_c  = w0 & {3{edge_ok.left_ok}};
    right_c = w2 & {3{edge_ok.right_ok}};
    left_c[0]  = left_c[0]  & edge_ok.top_ok;
    left_c[2]  = left_c[2]  & edge_ok.bottom_ok;
    right_c[0] = right_c[0] & edge_ok.top_ok;
    right_c[2] = right_c[2] & edge_ok.bottom_ok;
    up_c = w1[0] & edge_ok.top_ok;
    dn_c = w1[2] & edge_ok.bottom_ok;
    n = 4'(left_c[0]) + 4'(left_c[1]) + 4'(left_c[2])
      + 4'(right_c[0]) + 4'(right_c[1]) + 4'(right_c[2])
      + 4'(up_c) + 4'(dn_c);
    next_bit = (n == 4'd3) | (w1[1] & (n == 4'd2));
  end

endmodule

/* design/life_generation_engine_core.sv */
// Top level of the life generation engine: stream ports, config registers,
// grid memory, control FSM and the line-buffer chain. Uses lge_pkg,
// lge_cell and lge_rule.
`timescale 1ns / 1ps

// After reset the engine clears its 64 x 256 grid memory, one cell per cycle;
// s_tready stays low during that pass. A write command and any out-of-range
// access return their word the cycle after acceptance; an in-range read first
// passes through ST_READ because the grid memory has a registered read port. A
// step streams every stored cell through the single read port and writes each
// new cell back through the write port once it has passed the line buffer and
// the 3x3 window; s_tready stays low while it runs, and its word is loaded when
// the step counter reaches STEP_END. One command is in flight at a time; a new
// one is accepted while the previous result word still waits in the output
// register only if that word is taken in the same cycle.
module life_generation_engine_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // cmd[1:0], row[7:2], col[15:8], cell_value[16], zero pad
  input  logic [lge_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // read_value[0], addr_error[1], zero pad
  output logic [lge_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        cfg_wr_en,
  input  logic [lge_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lge_pkg::CFG_W-1:0]   cfg_wdata
);
  import lge_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_STEP  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [NR_W-1:0]   rows_cfg;
  logic [NC_W-1:0]   cols_cfg;
  logic [NR_W-1:0]   nr;
  logic [NC_W-1:0]   nc;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  center;
  logic [ROW_W-1:0]  cr;
  logic [COL_W-1:0]  cc;

  logic [1:0]        in_cmd;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic              in_val;
  logic              in_err;
  logic              accept;

  logic              mem [GRID_CELLS];
  logic              mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic              mem_wd;
  logic [ADDR_W-1:0] mem_ra;

  logic [MAX_COLS:0] la;
  logic [MAX_COLS:0] lb;
  lge_edge_t         edge_ok;
  logic              rule_bit;
  logic              step_wr;

  logic              load_out;
  logic [1:0]        out_next;
  logic [1:0]        out_data;

  assign in_cmd = s_tdata[1:0];
  assign in_row = s_tdata[2 +: ROW_W];
  assign in_col = s_tdata[2 + ROW_W +: COL_W];
  assign in_val = s_tdata[2 + ROW_W + COL_W];

  assign nr = (rows_cfg > NR_W'(MAX_ROWS)) ? NR_W'(MAX_ROWS) : rows_cfg;
  assign nc = (cols_cfg > NC_W'(MAX_COLS)) ? NC_W'(MAX_COLS) : cols_cfg;

  assign in_err = ({1'b0, in_row} >= nr) || ({1'b0, in_col} >= nc);

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= NR_W'(60);
      cols_cfg <= NC_W'(160);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROWS: rows_cfg <= cfg_wdata[NR_W-1:0];
        REG_COLS: cols_cfg <= cfg_wdata[NC_W-1:0];
        default: ;
      endcase
    end
  end

  // step window center coordinates
  assign center = cnt - CNT_W'(LAG);
  assign cr     = center[COL_W +: ROW_W];
  assign cc     = center[COL_W-1:0];

  assign edge_ok.top_ok    = (cr != '0);
  assign edge_ok.left_ok   = (cc != '0);
  assign edge_ok.bottom_ok = ({1'b0, cr} + NR_W'(1)) < nr;
  assign edge_ok.right_ok  = ({1'b0, cc} + NC_W'(1)) < nc;

  assign step_wr = (state == ST_STEP) && (cnt >= CNT_W'(LAG))
                && ({1'b0, cr} < nr) && ({1'b0, cc} < nc);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = {in_row, in_col};
    mem_wd = in_val;
    mem_ra = {in_row, in_col};
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt[ADDR_W-1:0];
        mem_wd = 1'b0;
      end
      ST_STEP: begin
        mem_we = step_wr;
        mem_wa = center[ADDR_W-1:0];
        mem_wd = rule_bit;
        mem_ra = cnt[ADDR_W-1:0];
      end
      default: begin
        mem_we = accept && (in_cmd == CMD_WRITE) && !in_err;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  // two-line buffer: la taps give the line above, lb the line two above
  assign la[0] = mem_q;
  assign lb[0] = la[MAX_COLS];

  for (genvar k = 0; k < MAX_COLS; k++) begin : g_line
    lge_cell u_cell (
      .clk   (clk),
      .shift (state == ST_STEP),
      .a_in  (la[k]),
      .b_in  (lb[k]),
      .a_out (la[k+1]),
      .b_out (lb[k+1])
    );
  end

  lge_rule u_rule (
    .clk      (clk),
    .shift    (state == ST_STEP),
    .col_in   ({mem_q, la[MAX_COLS], lb[MAX_COLS]}),
    .edge_ok  (edge_ok),
    .next_bit (rule_bit)
  );

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    out_next   = 2'b00;
    case (state)
      ST_CLEAR: begin
        if (cnt == CNT_W'(GRID_CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_STEP) begin
            state_next = ST_STEP;
          end else if (in_cmd == CMD_READ && !in_err) begin
            state_next = ST_READ;
          end else begin
            load_out = 1'b1;
            out_next = {in_err && (in_cmd == CMD_WRITE || in_cmd == CMD_READ), 1'b0};
          end
        end
      end
      ST_READ: begin
        load_out   = 1'b1;
        out_next   = {1'b0, mem_q};
        state_next = ST_IDLE;
      end
      ST_STEP: begin
        if (cnt == CNT_W'(STEP_END)) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
  end

  assign m_tdata = {{(OUT_W-2){1'b0}}, out_data};

  a_no_accept_in_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP || state == ST_CLEAR) |-> !s_tready)
    else $error("input accepted while grid busy");

  a_step_write_lags: assert property (@(posedge clk) disable iff (rst)
    step_wr |-> (cnt >= CNT_W'(LAG)) && (cnt <= CNT_W'(STEP_END)))
    else $error("step write outside window lag");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_READ) || $past(state == ST_STEP)
                        || $past(accept))
    else $error("result word without a command");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !m_tvalid)
    else $error("result word during clearing pass");

endmodule
